FILE: hdl/sepia_tone_pixel_macros.svh
// Assertion macros shared by the sepia tone pixel RTL.
// Expects clk and rst (synchronous, active high) in the including module.
`ifndef SEPIA_TONE_PIXEL_MACROS_SVH
`define SEPIA_TONE_PIXEL_MACROS_SVH

// Same-cycle implication, held off during reset.
`define STP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define STP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/stp_pkg.sv
// Sepia tone pixel package: widths, matrix constants, pixel and coefficient types.
// No dependencies; used by every module of the block.
package stp_pkg;

  localparam int CH_W    = 8;   // colour channel
  localparam int INT_W   = 7;   // intensity register
  localparam int COEF_W  = 17;  // coefficient, units of 1/100000
  localparam int SLOPE_W = 10;  // per-percent matrix slope
  localparam int MUL_W   = CH_W + COEF_W;     // one product
  localparam int SUM_W   = MUL_W + 1;         // sum of three products
  localparam int QUOT_W  = 9;                 // quotient, at most 344
  localparam int RECIP_SHIFT = 32;
  localparam int EST_W   = RECIP_SHIFT + QUOT_W;  // sum times reciprocal

  localparam logic [COEF_W-1:0] DENOM      = 17'd100000;
  localparam logic [SUM_W-1:0]  DENOM_SUM  = 26'd100000;
  localparam logic [SUM_W-1:0]  DENOM_TWICE = 26'd200000;
  // floor(2^32 / 100000); estimate is exact or one low for sums below 2^26
  localparam logic [EST_W-1:0]  RECIP      = 41'd42949;
  localparam logic [INT_W-1:0]  INT_MAX    = 7'd100;
  localparam logic [INT_W-1:0]  INT_RESET  = 7'd30;
  localparam logic [QUOT_W-1:0] CH_MAX_Q   = 9'd255;

  // Matrix slopes, row major (red, green, blue rows; r, g, b columns)
  localparam logic [SLOPE_W-1:0] SLOPE [9] = '{
    10'd607, 10'd769, 10'd189,
    10'd349, 10'd314, 10'd168,
    10'd272, 10'd534, 10'd869
  };
  // Diagonal entries blend down from the identity
  localparam logic [8:0] DIAG = 9'b100_010_001;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  typedef logic [8:0][COEF_W-1:0] coef_set_t;
  typedef logic [2:0][SUM_W-1:0]  sum_set_t;

  function automatic coef_set_t coef_of(input logic [INT_W-1:0] level);
    coef_set_t c;
    logic [COEF_W-1:0] p;
    for (int k = 0; k < 9; k++) begin
      p = {{(COEF_W-SLOPE_W){1'b0}}, SLOPE[k]} * {{(COEF_W-INT_W){1'b0}}, level};
      c[k] = DIAG[k] ? DENOM - p : p;
    end
    return c;
  endfunction

endpackage

FILE: hdl/stp_coef.sv
// Intensity register: clamps writes to 100 and holds the blended matrix.
// Depends on stp_pkg.
module stp_coef (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [stp_pkg::INT_W-1:0] cfg_wdata,
  output stp_pkg::coef_set_t        coef
);

  logic [stp_pkg::INT_W-1:0] level;

  // values above 100 act as 100
  assign level = (cfg_wdata > stp_pkg::INT_MAX) ? stp_pkg::INT_MAX : cfg_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= stp_pkg::coef_of(stp_pkg::INT_RESET);
    end else if (cfg_we) begin
      coef <= stp_pkg::coef_of(level);
    end
  end

endmodule

FILE: hdl/stp_matrix.sv
// Matrix stages: nine products, then three row sums.
// Depends on stp_pkg.
module stp_matrix (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  stp_pkg::pixel_t     in_px,
  input  stp_pkg::coef_set_t  coef,
  output logic                out_valid,
  input  logic                out_ready,
  output stp_pkg::sum_set_t   out_sum,
  output logic [stp_pkg::CH_W-1:0] out_alpha
);

  logic                        v1;
  logic                        en1;
  logic                        en2;
  logic [8:0][stp_pkg::MUL_W-1:0] prod;
  logic [stp_pkg::CH_W-1:0]    alpha1;
  logic [2:0][stp_pkg::CH_W-1:0] comp;

  assign comp = {in_px.blue, in_px.green, in_px.red};

  assign en2      = !out_valid || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) out_valid <= v1;
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int k = 0; k < 9; k++) begin
        prod[k] <= {{stp_pkg::COEF_W{1'b0}}, comp[k % 3]}
                 * {{stp_pkg::CH_W{1'b0}}, coef[k]};
      end
      alpha1 <= in_px.alpha;
    end
  end

  // stage 2: row sums
  always_ff @(posedge clk) begin
    if (en2) begin
      for (int r = 0; r < 3; r++) begin
        out_sum[r] <= {1'b0, prod[3*r]} + {1'b0, prod[3*r+1]} + {1'b0, prod[3*r+2]};
      end
      out_alpha <= alpha1;
    end
  end

endmodule

FILE: hdl/stp_div.sv
// Divide-by-100000 stages: reciprocal estimate, back-multiply, correct and saturate.
// Depends on stp_pkg and sepia_tone_pixel_macros.svh.
`include "sepia_tone_pixel_macros.svh"

module stp_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  stp_pkg::sum_set_t        in_sum,
  input  logic [stp_pkg::CH_W-1:0] in_alpha,
  output logic                     out_valid,
  input  logic                     out_ready,
  output stp_pkg::pixel_t          out_px
);

  logic v3;
  logic v4;
  logic en3;
  logic en4;
  logic en5;

  logic [2:0][stp_pkg::EST_W-1:0]  est3;
  stp_pkg::sum_set_t               sum3;
  logic [stp_pkg::CH_W-1:0]        alpha3;
  logic [2:0][stp_pkg::QUOT_W-1:0] q4;
  logic [2:0][stp_pkg::SUM_W-1:0]  back4;
  stp_pkg::sum_set_t               sum4;
  logic [stp_pkg::CH_W-1:0]        alpha4;
  logic [2:0][stp_pkg::SUM_W-1:0]  rem4;
  logic [2:0][stp_pkg::QUOT_W-1:0] qfix;
  logic [2:0][stp_pkg::CH_W-1:0]   chan;

  assign en5      = !out_valid || out_ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign in_ready = en3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en3) v3 <= in_valid;
      if (en4) v4 <= v3;
      if (en5) out_valid <= v4;
    end
  end

  // stage 3: sum times reciprocal
  always_ff @(posedge clk) begin
    if (en3) begin
      for (int c = 0; c < 3; c++) begin
        est3[c] <= {{(stp_pkg::EST_W-stp_pkg::SUM_W){1'b0}}, in_sum[c]} * stp_pkg::RECIP;
      end
      sum3   <= in_sum;
      alpha3 <= in_alpha;
    end
  end

  // stage 4: quotient estimate and its product with the divisor
  always_ff @(posedge clk) begin
    if (en4) begin
      for (int c = 0; c < 3; c++) begin
        q4[c]    <= est3[c][stp_pkg::EST_W-1:stp_pkg::RECIP_SHIFT];
        back4[c] <= {{stp_pkg::COEF_W{1'b0}},
                     est3[c][stp_pkg::EST_W-1:stp_pkg::RECIP_SHIFT]}
                  * {{stp_pkg::QUOT_W{1'b0}}, stp_pkg::DENOM};
      end
      sum4   <= sum3;
      alpha4 <= alpha3;
    end
  end

  // stage 5: estimate is exact or one low; then clip to 255
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rem4[c] = sum4[c] - back4[c];
      qfix[c] = q4[c] + {{(stp_pkg::QUOT_W-1){1'b0}}, (rem4[c] >= stp_pkg::DENOM_SUM)};
      chan[c] = (qfix[c] > stp_pkg::CH_MAX_Q) ? {stp_pkg::CH_W{1'b1}}
                                              : qfix[c][stp_pkg::CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      out_px.red   <= chan[0];
      out_px.green <= chan[1];
      out_px.blue  <= chan[2];
      out_px.alpha <= alpha4;
    end
  end

  `STP_ASSERT_IMP(a_est_not_high, v4, (back4[0] <= sum4[0]) && (back4[1] <= sum4[1]) && (back4[2] <= sum4[2]), "reciprocal estimate above true quotient")
  `STP_ASSERT_IMP(a_rem_bound, v4, (rem4[0] < stp_pkg::DENOM_TWICE) && (rem4[1] < stp_pkg::DENOM_TWICE) && (rem4[2] < stp_pkg::DENOM_TWICE), "quotient estimate more than one low")
  `STP_ASSERT_NXT(a_stage_advance, v4 && en5, out_valid, "item lost between last two stages")

endmodule

FILE: hdl/sepia_tone_pixel.sv
// Sepia tone pixel, top level: stream ports, intensity register, pipeline.
// Depends on stp_pkg, stp_coef, stp_matrix, stp_div and sepia_tone_pixel_macros.svh.
//
// Use:
//  - s_* takes one ARGB pixel per item, m_* gives one sepia pixel per item.
//    tdata packs red, green, blue, alpha, 8 bits each, red in the lowest byte.
//  - cfg_we/cfg_wdata write the intensity (percent, 0..100; larger acts as 100).
//    Write it only while no pixel is in flight; it takes effect next cycle.
//  - Each output channel is floor(row . rgb / 100000), clipped at 255, where
//    the row blends the sepia matrix with identity by the intensity.
//  - Pipeline: five registered stages from acceptance to m_tvalid (products, row sums,
//    reciprocal multiply, back-multiply, correction and clip).
//  - Throughput: one item per clock while m_tready stays high; every stage carries a valid bit.
//  - Stall: ready runs back through the stages, so bubbles are squeezed out and
//    s_tready falls only once all five stages hold items and m_tready is low.
//    The output register holds its item until taken.
//  - Reset: empties the pipeline and sets intensity back to 30.
`include "sepia_tone_pixel_macros.svh"

module sepia_tone_pixel (
  input  logic                      clk,
  input  logic                      rst,
  // config
  input  logic                      cfg_we,
  input  logic [stp_pkg::INT_W-1:0] cfg_wdata,
  // input item
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [31:0]               s_tdata,   // red_in, green_in, blue_in, alpha_in
  // result item
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [31:0]               m_tdata    // red_out, green_out, blue_out, alpha_out
);

  stp_pkg::coef_set_t        coef;
  stp_pkg::sum_set_t         sum;
  logic [stp_pkg::CH_W-1:0]  sum_alpha;
  logic                      sum_valid;
  logic                      sum_ready;
  stp_pkg::pixel_t           px_in;
  stp_pkg::pixel_t           px_out;

  assign px_in   = stp_pkg::pixel_t'(s_tdata);
  assign m_tdata = px_out;

  // blended matrix, recomputed on each write
  stp_coef u_coef (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .coef      (coef)
  );

  // products and row sums
  stp_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_px     (px_in),
    .coef      (coef),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .out_sum   (sum),
    .out_alpha (sum_alpha)
  );

  // divide, correct, clip
  stp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .in_sum    (sum),
    .in_alpha  (sum_alpha),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_px    (px_out)
  );

  // input only backs up when the whole pipe is full and the output stalled
  `STP_ASSERT_IMP(a_full_stall, !s_tready, m_tvalid && !m_tready && sum_valid && !sum_ready, "input stalled with room in the pipeline")

endmodule

FILE: tb/tb.sv
// Self-checking testbench for sepia_tone_pixel: directed table, then random pixels.
// Depends on stp_pkg (widths, pixel_t) and the sepia_tone_pixel RTL.
`timescale 1ns / 1ps

module tb;

  // Blend arithmetic, in units of 1/100000
  localparam int unsigned SCALE    = 100000;
  localparam int unsigned LVL_TOP  = 100;   // anything above acts as this
  localparam int unsigned CHAN_TOP = 255;
  localparam int unsigned HOLD_CYCLES = 60; // long receiver hold-off

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [stp_pkg::INT_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;  // red_in, green_in, blue_in, alpha_in
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;       // red_out, green_out, blue_out, alpha_out

  // One directed row: level to run at, pixel, and optionally a typed-in answer
  typedef struct {
    logic [stp_pkg::INT_W-1:0] lvl;
    stp_pkg::pixel_t px;
    bit typed;
    stp_pkg::pixel_t want;
  } tone_row_t;

  // Answers typed in only where obvious: black, identity at 0, white at full
  // strength (blue lands on 238), pure blue at full strength, and 127 acting as 100.
  tone_row_t tone_tab [20] = '{
    '{7'd30,  32'h00000000, 1'b1, 32'h00000000},
    '{7'd30,  32'hFFFFFFFF, 1'b0, 32'h0},
    '{7'd30,  32'h000000FF, 1'b0, 32'h0},
    '{7'd30,  32'h0000FF00, 1'b0, 32'h0},
    '{7'd30,  32'h00FF0000, 1'b0, 32'h0},
    '{7'd30,  32'h5AA55AA5, 1'b0, 32'h0},
    '{7'd0,   32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
    '{7'd0,   32'h78563412, 1'b1, 32'h78563412},
    '{7'd0,   32'h00000000, 1'b1, 32'h00000000},
    '{7'd100, 32'hFF000000, 1'b1, 32'hFF000000},
    '{7'd100, 32'h00FFFFFF, 1'b1, 32'h00EEFFFF},
    '{7'd100, 32'h000000FF, 1'b0, 32'h0},
    '{7'd100, 32'h0000FF00, 1'b0, 32'h0},
    '{7'd100, 32'h00FF0000, 1'b1, 32'h00212A30},
    '{7'd100, 32'hA5102030, 1'b0, 32'h0},
    '{7'd127, 32'h80FFFFFF, 1'b1, 32'h80EEFFFF},
    '{7'd127, 32'h00FF0000, 1'b1, 32'h00212A30},
    '{7'd101, 32'h7F808080, 1'b0, 32'h0},
    '{7'd1,   32'hFFFFFFFF, 1'b0, 32'h0},
    '{7'd64,  32'h01020304, 1'b0, 32'h0}
  };

  string chan_tag [4] = '{"red_out", "green_out", "blue_out", "alpha_out"};

  stp_pkg::pixel_t sepia_due [$];        // expected output pixels, oldest first
  logic [stp_pkg::INT_W-1:0] tone_lvl = stp_pkg::INT_RESET;  // our copy of the register
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int n_fail = 0;
  stp_pkg::pixel_t got_px, want_px;

  sepia_tone_pixel u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // floor(sum / 100000), clipped to a channel
  function automatic logic [7:0] clip_chan(input int unsigned sum);
    int unsigned q;
    q = sum / SCALE;
    return (q > CHAN_TOP) ? 8'(CHAN_TOP) : 8'(q);
  endfunction

  // Sepia matrix blended with identity by the level, alpha straight through
  function automatic stp_pkg::pixel_t sepia_of(input stp_pkg::pixel_t px,
                                               input logic [stp_pkg::INT_W-1:0] lvl);
    int unsigned i, r, g, b;
    stp_pkg::pixel_t res;
    i = (lvl > LVL_TOP) ? LVL_TOP : lvl;
    r = px.red;
    g = px.green;
    b = px.blue;
    res.red   = clip_chan(r * (SCALE - 607 * i) + g * (769 * i) + b * (189 * i));
    res.green = clip_chan(r * (349 * i) + g * (SCALE - 314 * i) + b * (168 * i));
    res.blue  = clip_chan(r * (272 * i) + g * (534 * i) + b * (SCALE - 869 * i));
    res.alpha = px.alpha;
    return res;
  endfunction

  // Channels lean towards 0 and 255 so clipping and the corners get hit often
  function automatic logic [7:0] rand_chan();
    int unsigned k;
    k = $urandom_range(9);
    if (k == 0) return 8'h00;
    if (k == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic stp_pkg::pixel_t rand_pixel();
    stp_pkg::pixel_t px;
    px.red   = rand_chan();
    px.green = rand_chan();
    px.blue  = rand_chan();
    px.alpha = 8'($urandom);
    return px;
  endfunction

  // Offer one pixel after a random gap; the answer is queued on acceptance.
  // tvalid stays high into the next call unless that call idles first.
  task automatic offer_pixel(input stp_pkg::pixel_t px, input bit typed,
                             input stp_pkg::pixel_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk); while (!s_tready);
    sepia_due.push_back(typed ? want : sepia_of(px, tone_lvl));
  endtask

  // Stop offering and wait for every queued answer to come out
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sepia_due.size() != 0) @(posedge clk);
  endtask

  // Intensity is only changed with the pipeline empty
  task automatic set_intensity(input logic [stp_pkg::INT_W-1:0] lvl);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= lvl;
    @(posedge clk);
    cfg_we   <= 1'b0;
    tone_lvl  = lvl;
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request so
  // the pipeline fills and s_tready has to drop.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Result checker: each taken item against the oldest answer, per channel
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (sepia_due.size() == 0) begin
        $error("unexpected output item: m_tdata %08h", m_tdata);
        n_fail++;
      end else begin
        want_px = sepia_due.pop_front();
        got_px  = m_tdata;
        for (int k = 0; k < 4; k++) begin
          if (got_px[k*8 +: 8] !== want_px[k*8 +: 8]) begin
            $error("%s: expected %0d, actual %0d", chan_tag[k],
                   want_px[k*8 +: 8], got_px[k*8 +: 8]);
            n_fail++;
          end
        end
      end
    end
  end

  // Stimulus: directed table, then three idling modes of random pixels
  initial begin
    int unsigned tx_mode [3];
    int unsigned rx_mode [3];
    logic [stp_pkg::INT_W-1:0] lvl;
    tx_mode = '{23, 66, 0};
    rx_mode = '{66, 23, 0};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed rows at mild idling; the level is rewritten where it changes
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    foreach (tone_tab[n]) begin
      if (tone_tab[n].lvl != tone_lvl) set_intensity(tone_tab[n].lvl);
      offer_pixel(tone_tab[n].px, tone_tab[n].typed, tone_tab[n].want);
    end

    // Five settings per mode: 0, 100, 127 (acts as 100), then two random
    for (int m = 0; m < 3; m++) begin
      tx_idle_pct = tx_mode[m];
      rx_idle_pct = rx_mode[m];
      for (int seg = 0; seg < 5; seg++) begin
        case (seg)
          0: lvl = 7'd0;
          1: lvl = 7'd100;
          2: lvl = 7'd127;
          default: lvl = 7'($urandom_range(127));
        endcase
        set_intensity(lvl);
        for (int n = 0; n < 100; n++) begin
          // With no idling, hold the receiver off once while we keep pushing
          if (m == 2 && seg == 3 && n == 20) hold_go = 1'b1;
          offer_pixel(rand_pixel(), 1'b0, '0);
        end
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (n_fail == 0) begin
      $display("sepia_tone_pixel regression: pass");
    end else begin
      $display("sepia_tone_pixel regression: fail");
    end
    $finish;
  end

  // Watchdog, far above the slowest correct run
  initial begin
    #5000000;
    $display("sepia_tone_pixel regression: fail");
    $finish;
  end

endmodule
